[hdl/tss_pkg.sv]
// shared types, codes and constants of the timed stage sequencer
`timescale 1ns / 1ps

package tss_pkg;

    // default table depth
    localparam int STAGES_DEF = 16;

    // widths of the stage pointer and stage count register
    localparam int CUR_W = 5;

    // configuration port
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] REG_STAGE_COUNT = 3'd0;
    localparam logic [CUR_W-1:0] STAGE_COUNT_RESET = 5'd1;

    // request opcodes
    typedef enum logic [1:0] {
        OP_UPDATE  = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RESTART = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    // stage phases, also the action code reported with a callback
    typedef enum logic [1:0] {
        PH_ENTRY = 2'd0,
        PH_RUN   = 2'd1,
        PH_EXIT  = 2'd2
    } t_phase;

    // stage table word selector
    typedef enum logic [2:0] {
        FLD_TIMEOUT  = 3'd0,
        FLD_PERIOD   = 3'd1,
        FLD_COND     = 3'd2,
        FLD_RANGE_LO = 3'd3,
        FLD_RANGE_HI = 3'd4
    } t_field;

    // condition kinds held in the low bits of the condition word
    typedef enum logic [2:0] {
        COND_NONE   = 3'd0,
        COND_BIT    = 3'd1,
        COND_ANY    = 3'd2,
        COND_ACTION = 3'd3,
        COND_RANGE  = 3'd4
    } t_cond_kind;

    // table write request
    typedef struct packed {
        logic        en;
        logic [3:0]  index;
        logic [2:0]  field;
        logic [31:0] value;
    } t_tbl_wr;

    // one stage table entry as read back
    typedef struct packed {
        logic [31:0] timeout;
        logic [31:0] period;
        logic [6:0]  cond;
        logic [31:0] range_lo;
        logic [31:0] range_hi;
    } t_stage_entry;

endpackage

[hdl/tss_table.sv]
// stage table memories with registered write-first read of the current stage
`timescale 1ns / 1ps

module tss_table import tss_pkg::*; #(
    parameter int STAGES = STAGES_DEF
) (
    input  logic             i_clk,
    input  t_tbl_wr          i_wr,
    input  logic [CUR_W-1:0] i_rd_addr,
    output t_stage_entry     o_entry
);

    localparam int AW = (STAGES > 1) ? $clog2(STAGES) : 1;

    logic [31:0] r_timeout_mem [0:STAGES-1];
    logic [31:0] r_period_mem  [0:STAGES-1];
    logic [6:0]  r_cond_mem    [0:STAGES-1];
    logic [31:0] r_lo_mem      [0:STAGES-1];
    logic [31:0] r_hi_mem      [0:STAGES-1];

    logic [31:0] r_timeout;
    logic [31:0] r_period;
    logic [6:0]  r_cond;
    logic [31:0] r_lo;
    logic [31:0] r_hi;

    logic [AW+CUR_W-1:0] rd_wide;
    logic [AW+3:0]       wr_wide;
    logic [AW-1:0]       raddr;
    logic [AW-1:0]       waddr;
    logic                wr_ok;
    logic                same;
    logic                we_timeout;
    logic                we_period;
    logic                we_cond;
    logic                we_lo;
    logic                we_hi;

    // address mapping onto the table depth
    assign rd_wide = {{AW{1'b0}}, i_rd_addr};
    assign wr_wide = {{AW{1'b0}}, i_wr.index};
    assign raddr   = rd_wide[AW-1:0];
    assign waddr   = wr_wide[AW-1:0];
    assign wr_ok   = i_wr.en && (32'(i_wr.index) < 32'(STAGES));
    assign same    = (CUR_W'(i_wr.index) == i_rd_addr);

    // field decode of the write request
    always_comb begin
        we_timeout = 1'b0;
        we_period  = 1'b0;
        we_cond    = 1'b0;
        we_lo      = 1'b0;
        we_hi      = 1'b0;
        case (t_field'(i_wr.field))
            FLD_TIMEOUT:  we_timeout = wr_ok;
            FLD_PERIOD:   we_period  = wr_ok;
            FLD_COND:     we_cond    = wr_ok;
            FLD_RANGE_LO: we_lo      = wr_ok;
            FLD_RANGE_HI: we_hi      = wr_ok;
            default: begin
            end
        endcase
    end

    // timeout table
    always_ff @(posedge i_clk) begin
        if (we_timeout) begin
            r_timeout_mem[waddr] <= i_wr.value;
        end
        r_timeout <= (we_timeout && same) ? i_wr.value : r_timeout_mem[raddr];
    end

    // period table
    always_ff @(posedge i_clk) begin
        if (we_period) begin
            r_period_mem[waddr] <= i_wr.value;
        end
        r_period <= (we_period && same) ? i_wr.value : r_period_mem[raddr];
    end

    // condition table
    always_ff @(posedge i_clk) begin
        if (we_cond) begin
            r_cond_mem[waddr] <= i_wr.value[6:0];
        end
        r_cond <= (we_cond && same) ? i_wr.value[6:0] : r_cond_mem[raddr];
    end

    // range low table
    always_ff @(posedge i_clk) begin
        if (we_lo) begin
            r_lo_mem[waddr] <= i_wr.value;
        end
        r_lo <= (we_lo && same) ? i_wr.value : r_lo_mem[raddr];
    end

    // range high table
    always_ff @(posedge i_clk) begin
        if (we_hi) begin
            r_hi_mem[waddr] <= i_wr.value;
        end
        r_hi <= (we_hi && same) ? i_wr.value : r_hi_mem[raddr];
    end

    assign o_entry.timeout  = r_timeout;
    assign o_entry.period   = r_period;
    assign o_entry.cond     = r_cond;
    assign o_entry.range_lo = r_lo;
    assign o_entry.range_hi = r_hi;

endmodule

[hdl/timed_stage_sequencer.sv]
// top level of the timed stage sequencer
`timescale 1ns / 1ps

// Request channel: i_in_valid / o_in_stall with op, tick and sampled inputs.
// An update request steps the current stage through entry, run and exit;
// write requests load stage table words, restart requests rewind to stage 0.
// Result channel: o_out_valid / i_out_stall, one result per request.
// Requests pass an input register, then the single-pass stage logic into
// the result register. One request is taken every cycle unless stalled; the
// stage table is read through registered memory ports addressed with the
// next stage pointer, so back-to-back updates see the stage just entered.
// When the receiver stalls, the result register holds and one more request
// is taken into the input register; o_in_stall rises only when both are full.
// The APB port holds stage_count at byte address 0; pready is always high.
// Reset (i_rst_n low, synchronous) empties both registers, sets stage 0 in
// its entry phase and stage_count to 1. Stage table contents are undefined
// until written and must be loaded before the stage that uses them runs.
module timed_stage_sequencer import tss_pkg::*; #(
    parameter int STAGES = STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic [63:0]        i_now,
    input  logic               i_exit_request,
    input  logic               i_sampled_bit,
    input  logic               i_sampled_any_bit,
    input  logic [2:0]         i_sampled_bit_action,
    input  logic [31:0]        i_sampled_level,
    input  logic [3:0]         i_stage_index,
    input  logic [2:0]         i_stage_field,
    input  logic [31:0]        i_stage_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_call_fires,
    output logic [1:0]         o_action,
    output logic [3:0]         o_stage,
    output logic [63:0]        o_elapsed,
    output logic               o_running,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int MAX_USED = (STAGES < 31) ? STAGES : 31;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_in_op;
    logic [63:0] r_in_now;
    logic        r_in_exit;
    logic        r_in_bit;
    logic        r_in_any;
    logic [2:0]  r_in_code;
    logic [31:0] r_in_level;
    logic [3:0]  r_in_index;
    logic [2:0]  r_in_field;
    logic [31:0] r_in_value;

    // result register
    logic        r_out_valid;
    logic        r_out_fires;
    logic [1:0]  r_out_action;
    logic [3:0]  r_out_stage;
    logic [63:0] r_out_elapsed;
    logic        r_out_running;

    // sequencer state
    logic [CUR_W-1:0] r_stage_count;
    logic [CUR_W-1:0] r_cur;
    t_phase           r_phase;
    logic [63:0]      r_start;
    logic [63:0]      r_npt;
    logic [CUR_W-1:0] n_cur;
    t_phase           n_phase;
    logic [63:0]      n_start;
    logic [63:0]      n_npt;

    // result next values
    logic        n_out_fires;
    logic [1:0]  n_out_action;
    logic [3:0]  n_out_stage;
    logic [63:0] n_out_elapsed;
    logic        n_out_running;

    logic         in_accept;
    logic         consume;
    logic         cfg_wr;
    t_tbl_wr      tbl_wr;
    logic [CUR_W-1:0] rd_addr;
    t_stage_entry entry;

    logic [CUR_W-1:0] used;
    logic         finished;
    logic         last_stage;
    logic [64:0]  tmo_sum;
    logic         tmo_hit;
    logic         cond_hit;
    logic         leave;
    t_phase       eff_phase;
    logic         per_on;
    logic         skip;
    logic [63:0]  elapsed;
    logic         has_cb;

    // handshakes
    assign consume    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op    <= i_op;
            r_in_now   <= i_now;
            r_in_exit  <= i_exit_request;
            r_in_bit   <= i_sampled_bit;
            r_in_any   <= i_sampled_any_bit;
            r_in_code  <= i_sampled_bit_action;
            r_in_level <= i_sampled_level;
            r_in_index <= i_stage_index;
            r_in_field <= i_stage_field;
            r_in_value <= i_stage_value;
        end
    end

    // configuration register
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_STAGE_COUNT);
    assign pready = 1'b1;
    assign prdata = (paddr == REG_STAGE_COUNT) ? {{(32-CUR_W){1'b0}}, r_stage_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_count <= STAGE_COUNT_RESET;
        end else if (cfg_wr) begin
            r_stage_count <= pwdata[CUR_W-1:0];
        end
    end

    // stage table, read at the stage pointer that the next request sees
    assign tbl_wr.en    = consume && (t_op'(r_in_op) == OP_WRITE);
    assign tbl_wr.index = r_in_index;
    assign tbl_wr.field = r_in_field;
    assign tbl_wr.value = r_in_value;
    assign rd_addr      = i_rst_n ? n_cur : '0;

    tss_table #(
        .STAGES(STAGES)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr     (tbl_wr),
        .i_rd_addr(rd_addr),
        .o_entry  (entry)
    );

    // stages in use, at least one and saturated to the table depth
    always_comb begin
        if (r_stage_count == '0) begin
            used = CUR_W'(1);
        end else if (32'(r_stage_count) > MAX_USED) begin
            used = CUR_W'(MAX_USED);
        end else begin
            used = r_stage_count;
        end
    end

    assign finished   = (r_cur >= used);
    assign last_stage = (({1'b0, r_cur} + 6'd1) >= {1'b0, used});
    assign has_cb     = entry.cond[6];
    assign per_on     = (entry.period != 32'd0);

    // timeout, never expires when zero or when start plus timeout overflows
    assign tmo_sum = {1'b0, r_start} + {33'd0, entry.timeout};
    assign tmo_hit = (entry.timeout != 32'd0) && !tmo_sum[64] && (tmo_sum[63:0] <= r_in_now);

    // selected input condition
    always_comb begin
        case (t_cond_kind'(entry.cond[2:0]))
            COND_BIT:    cond_hit = r_in_bit;
            COND_ANY:    cond_hit = r_in_any;
            COND_ACTION: cond_hit = (r_in_code == entry.cond[5:3]);
            COND_RANGE:  cond_hit = (r_in_level >= entry.range_lo)
                                    && (r_in_level <= entry.range_hi);
            default:     cond_hit = 1'b0;
        endcase
    end

    // phase this update acts in, with exit forced by timeout, condition or request
    always_comb begin
        leave     = (r_phase == PH_RUN) && (tmo_hit || cond_hit);
        eff_phase = (leave || r_in_exit) ? PH_EXIT : r_phase;
        skip      = (eff_phase == PH_RUN) && per_on && (r_npt > r_in_now);
        elapsed   = (eff_phase == PH_ENTRY) ? 64'd0 : (r_in_now - r_start);
    end

    // next state
    always_comb begin
        n_cur   = r_cur;
        n_phase = r_phase;
        n_start = r_start;
        n_npt   = r_npt;
        if (consume) begin
            case (t_op'(r_in_op))
                OP_UPDATE: begin
                    if (!finished && !skip) begin
                        case (eff_phase)
                            PH_ENTRY: begin
                                n_start = r_in_now;
                                n_phase = PH_RUN;
                                if (per_on) begin
                                    n_npt = r_in_now;
                                end
                            end
                            PH_RUN: begin
                                if (per_on) begin
                                    n_npt = r_npt + {32'd0, entry.period};
                                end
                            end
                            PH_EXIT: begin
                                n_cur   = r_cur + CUR_W'(1);
                                n_phase = last_stage ? PH_EXIT : PH_ENTRY;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                OP_RESTART: begin
                    n_cur   = '0;
                    n_phase = PH_ENTRY;
                    n_npt   = 64'd0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_phase <= PH_ENTRY;
            r_start <= 64'd0;
            r_npt   <= 64'd0;
        end else begin
            r_cur   <= n_cur;
            r_phase <= n_phase;
            r_start <= n_start;
            r_npt   <= n_npt;
        end
    end

    // result of the request in the input register
    always_comb begin
        n_out_fires   = 1'b0;
        n_out_action  = PH_ENTRY;
        n_out_stage   = 4'd0;
        n_out_elapsed = 64'd0;
        n_out_running = !finished;
        case (t_op'(r_in_op))
            OP_UPDATE: begin
                if (finished) begin
                    n_out_running = 1'b0;
                end else begin
                    n_out_fires   = has_cb && !skip;
                    n_out_action  = eff_phase;
                    n_out_stage   = r_cur[3:0];
                    n_out_elapsed = elapsed;
                    n_out_running = !((eff_phase == PH_EXIT) && !skip && last_stage);
                end
            end
            OP_RESTART: begin
                n_out_running = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume) begin
            r_out_fires   <= n_out_fires;
            r_out_action  <= n_out_action;
            r_out_stage   <= n_out_stage;
            r_out_elapsed <= n_out_elapsed;
            r_out_running <= n_out_running;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_call_fires = r_out_fires;
    assign o_action     = r_out_action;
    assign o_stage      = r_out_stage;
    assign o_elapsed    = r_out_elapsed;
    assign o_running    = r_out_running;

`ifndef SYNTHESIS
    // requests are refused only when both registers hold work
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("request stalled with a free register");

    // a restart rewinds to the entry of the first stage
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && (t_op'(r_in_op) == OP_RESTART)) |=> ((r_cur == '0) && (r_phase == PH_ENTRY)))
        else $error("restart did not rewind the sequence");

    // an entry callback always reports zero elapsed ticks
    a_entry_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fires && (r_out_action == PH_ENTRY)) |-> (r_out_elapsed == 64'd0))
        else $error("entry reported nonzero elapsed time");

    // a callback in a result that reports not running can only be the last exit
    a_last_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_running && r_out_fires) |-> (r_out_action == PH_EXIT))
        else $error("callback fired after the sequence ended");
`endif

endmodule
